// File: rtl/core/sfa_pkg.sv
// Shared types, codes and helpers of the sorted region first-fit allocator.
// No dependencies; used by sfa_cell and sorted_region_first_fit_allocator_core.
package sfa_pkg;

    // Field widths fixed by the request and result formats.
    localparam int UNIT_W  = 6;   // start unit, descriptor, slot
    localparam int LEN_W   = 10;  // length in bytes
    localparam int END_W   = 7;   // start plus allocation, up to 95
    localparam int SUM_W   = 8;   // end plus needed units, up to 127
    localparam int BYTES_W = 11;  // allocation in bytes, up to 1024
    localparam int UNIT_SHIFT = 5; // 32 bytes per unit

    // Register addresses on the configuration port.
    localparam logic [2:0] ADDR_VOLUME    = 3'd0;
    localparam logic [2:0] ADDR_READ_ONLY = 3'd4;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_RESIZE = 2'd1,
        OP_OPEN   = 2'd2,
        OP_CLOSE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TABLE_FULL   = 3'd1,
        ST_NO_SPACE     = 3'd2,
        ST_NOT_FOUND    = 3'd3,
        ST_ALREADY_OPEN = 3'd4,
        ST_NO_FIT       = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } t_state;

    // One table entry; a zero start marks an unused entry.
    typedef struct packed {
        logic [UNIT_W-1:0] start;
        logic [LEN_W-1:0]  len;
        logic              opened;
    } t_entry;

    // Request fields broadcast to every cell during a scan.
    typedef struct packed {
        t_op               op;
        logic [UNIT_W-1:0] desc;
        logic [LEN_W-1:0]  len;
        logic [UNIT_W-1:0] need;
        logic [UNIT_W-1:0] vol;
    } t_ctl;

    // Report of the cell that holds the scan token; all zero elsewhere.
    typedef struct packed {
        logic              hit;
        logic              fail;
        logic [UNIT_W-1:0] at;
        logic              fits;
        logic              opened;
    } t_rpt;

    // Table update broadcast once at the end of a successful request.
    typedef struct packed {
        logic              en;
        t_op               op;
        logic [UNIT_W-1:0] pos;
        logic [UNIT_W-1:0] at;
        logic [LEN_W-1:0]  len;
    } t_apply;

    // Units taken by a region: next power of two of the length, in whole
    // units, at least one.
    function automatic logic [UNIT_W-1:0] units_of(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]  v;
        logic [UNIT_W-1:0] u;
        v = len - LEN_W'(1);
        u = UNIT_W'(1);
        if (len > LEN_W'(32)) begin
            for (int b = UNIT_SHIFT; b < LEN_W; b++) begin
                if (v[b]) begin
                    u = UNIT_W'(1) << (b - UNIT_SHIFT + 1);
                end
            end
        end
        return u;
    endfunction

endpackage

// File: rtl/core/sfa_cell.sv
// One cell of the region table: holds one entry and passes the scan token on.
// Depends on sfa_pkg.
module sfa_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tok,
    input  logic [sfa_pkg::END_W-1:0]     i_tok_end,
    input  sfa_pkg::t_ctl                 i_ctl,
    input  sfa_pkg::t_apply               i_apply,
    input  sfa_pkg::t_entry               i_prev,
    output logic                          o_tok,
    output logic [sfa_pkg::END_W-1:0]     o_tok_end,
    output sfa_pkg::t_entry               o_entry,
    output sfa_pkg::t_rpt                 o_rpt,
    output logic                          o_vld
);

    localparam logic [sfa_pkg::UNIT_W-1:0] IDX_U = sfa_pkg::UNIT_W'(IDX);

    sfa_pkg::t_entry                  r_ent;
    logic                             r_tok;
    logic [sfa_pkg::END_W-1:0]        r_tok_end;
    logic                             w_vld;
    logic [sfa_pkg::UNIT_W-1:0]       w_units;
    logic [sfa_pkg::END_W-1:0]        w_end;
    logic [sfa_pkg::SUM_W-1:0]        w_sum;
    logic [sfa_pkg::BYTES_W-1:0]      w_bytes;
    logic                             w_hit;
    logic                             w_fail;

    // Token register: the token arrives from the left neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
        r_tok_end <= i_tok_end;
    end

    // Local geometry of this entry.
    assign w_vld   = (r_ent.start != '0);
    assign w_units = sfa_pkg::units_of(r_ent.len);
    assign w_end   = sfa_pkg::END_W'(r_ent.start) + sfa_pkg::END_W'(w_units);
    assign w_sum   = sfa_pkg::SUM_W'(r_tok_end) + sfa_pkg::SUM_W'(i_ctl.need);
    assign w_bytes = sfa_pkg::BYTES_W'(w_units) << sfa_pkg::UNIT_SHIFT;

    // Decide whether the scan stops here, and how.
    always_comb begin
        w_hit  = 1'b0;
        w_fail = 1'b0;
        if (r_tok) begin
            if (i_ctl.op == sfa_pkg::OP_ALLOC) begin
                if (w_vld) begin
                    w_hit = (w_sum <= sfa_pkg::SUM_W'(r_ent.start));
                end else begin
                    w_hit  = (w_sum <= sfa_pkg::SUM_W'(i_ctl.vol));
                    w_fail = !w_hit;
                end
            end else begin
                w_hit  = w_vld && (r_ent.start == i_ctl.desc);
                w_fail = !w_vld;
            end
        end
    end

    assign o_tok     = r_tok && !w_hit && !w_fail;
    assign o_tok_end = w_end;
    assign o_entry   = r_ent;
    assign o_vld     = w_vld;

    // Report, zero unless this cell holds the token.
    always_comb begin
        o_rpt        = '0;
        o_rpt.hit    = w_hit;
        o_rpt.fail   = w_fail;
        if (w_hit) begin
            o_rpt.at     = r_tok_end[sfa_pkg::UNIT_W-1:0];
            o_rpt.fits   = (sfa_pkg::BYTES_W'(i_ctl.len) <= w_bytes);
            o_rpt.opened = r_ent.opened;
        end
    end

    // Table update: insert with shift, resize, open or close.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
        end else if (i_apply.en) begin
            case (i_apply.op)
                sfa_pkg::OP_ALLOC: begin
                    if (IDX_U == i_apply.pos) begin
                        r_ent.start  <= i_apply.at;
                        r_ent.len    <= i_apply.len;
                        r_ent.opened <= 1'b0;
                    end else if (IDX_U > i_apply.pos) begin
                        r_ent <= i_prev;
                    end
                end
                sfa_pkg::OP_RESIZE: begin
                    if (IDX_U == i_apply.pos) begin
                        r_ent.len <= i_apply.len;
                    end
                end
                sfa_pkg::OP_OPEN: begin
                    if (IDX_U == i_apply.pos) begin
                        r_ent.opened <= 1'b1;
                    end
                end
                sfa_pkg::OP_CLOSE: begin
                    if (IDX_U == i_apply.pos) begin
                        r_ent.opened <= 1'b0;
                    end
                end
                default: begin
                    r_ent <= r_ent;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/sorted_region_first_fit_allocator_core.sv
// Top level of the sorted region first-fit allocator: chain of table cells,
// request sequencer, result register and configuration port. Uses sfa_pkg, sfa_cell.
//
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_op, i_descriptor, i_total_length
// result    out        o_valid / i_ready    o_status, o_slot, o_start_unit
// config    in         psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// After acceptance the scan token visits the cells in order, up to MAX_ENTRIES of
// them, one cell a cycle; the result is then registered and loaded for output.
// Allocation on a read-only volume or a full table answers without a scan.
// The next request is taken once the previous result sits in the output
// register; a stalled result holds the block in its final state.
// Reset is synchronous and empties the table; it needs no clearing pass.
module sorted_region_first_fit_allocator_core #(
    parameter int MAX_ENTRIES = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [5:0]  i_descriptor,
    input  logic [9:0]  i_total_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [5:0]  o_start_unit,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FIRST_UNIT = (2 + 2 * MAX_ENTRIES + 31) / 32;

    sfa_pkg::t_state                 r_state;
    sfa_pkg::t_state                 n_state;
    logic [5:0]                      r_volume;
    logic                            r_read_only;
    sfa_pkg::t_ctl                   r_ctl;
    logic [5:0]                      r_k;
    sfa_pkg::t_status                r_res_status;
    logic [5:0]                      r_res_slot;
    logic [5:0]                      r_res_start;
    logic                            r_o_valid;
    logic [2:0]                      r_o_status;
    logic [5:0]                      r_o_slot;
    logic [5:0]                      r_o_start;

    logic                            w_tok     [0:MAX_ENTRIES];
    logic [sfa_pkg::END_W-1:0]       w_tok_end [0:MAX_ENTRIES];
    sfa_pkg::t_entry                 w_ent     [0:MAX_ENTRIES-1];
    sfa_pkg::t_rpt                   w_rpt     [0:MAX_ENTRIES-1];
    logic [MAX_ENTRIES-1:0]          w_vld;
    logic [MAX_ENTRIES-1:0]          w_hit_vec;
    sfa_pkg::t_rpt                   w_rpt_or;
    sfa_pkg::t_apply                 w_apply;
    logic                            w_in_acc;
    logic                            w_imm;
    logic                            w_done;
    logic                            w_out_free;
    logic                            w_cfg_wr;
    sfa_pkg::t_status                w_scan_status;
    logic [5:0]                      w_scan_slot;
    logic [5:0]                      w_scan_start;

    // Configuration port: always ready, written on the access phase.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= 6'd63;
            r_read_only <= 1'b0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == sfa_pkg::ADDR_READ_ONLY[2]) begin
                r_read_only <= pwdata[0];
            end else begin
                r_volume <= pwdata[5:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == sfa_pkg::ADDR_VOLUME[1:0]) begin
            if (paddr[2] == sfa_pkg::ADDR_READ_ONLY[2]) begin
                prdata[0] = r_read_only;
            end else begin
                prdata[5:0] = r_volume;
            end
        end
    end

    // Request acceptance; allocation on a read-only volume or full table
    // needs no scan.
    assign o_ready  = (r_state == sfa_pkg::S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_imm    = (sfa_pkg::t_op'(i_op) == sfa_pkg::OP_ALLOC)
                      && (r_read_only || w_vld[MAX_ENTRIES-1]);

    // Scan token enters the first cell with the end of the header area.
    assign w_tok[0]     = w_in_acc && !w_imm;
    assign w_tok_end[0] = sfa_pkg::END_W'(FIRST_UNIT);

    // Chain of table cells.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        sfa_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (w_tok[g]),
            .i_tok_end (w_tok_end[g]),
            .i_ctl     (r_ctl),
            .i_apply   (w_apply),
            .i_prev    ((g == 0) ? '0 : w_ent[(g == 0) ? 0 : g - 1]),
            .o_tok     (w_tok[g+1]),
            .o_tok_end (w_tok_end[g+1]),
            .o_entry   (w_ent[g]),
            .o_rpt     (w_rpt[g]),
            .o_vld     (w_vld[g])
        );
        assign w_hit_vec[g] = w_rpt[g].hit;
    end

    // Only the cell holding the token reports, so an OR collects it.
    always_comb begin
        w_rpt_or = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_rpt_or = w_rpt_or | w_rpt[i];
        end
    end

    assign w_done = w_rpt_or.hit || w_rpt_or.fail || w_tok[MAX_ENTRIES];

    // Result of a finished scan.
    always_comb begin
        w_scan_status = sfa_pkg::ST_OK;
        w_scan_slot   = '0;
        w_scan_start  = '0;
        if (w_rpt_or.hit) begin
            w_scan_slot = r_k;
            case (r_ctl.op)
                sfa_pkg::OP_ALLOC: begin
                    w_scan_start = w_rpt_or.at;
                end
                sfa_pkg::OP_RESIZE: begin
                    w_scan_start  = r_ctl.desc;
                    w_scan_status = w_rpt_or.fits ? sfa_pkg::ST_OK : sfa_pkg::ST_NO_FIT;
                end
                sfa_pkg::OP_OPEN: begin
                    w_scan_start  = r_ctl.desc;
                    w_scan_status = w_rpt_or.opened ? sfa_pkg::ST_ALREADY_OPEN
                                                    : sfa_pkg::ST_OK;
                end
                default: begin
                    w_scan_start = r_ctl.desc;
                end
            endcase
        end else if (r_ctl.op == sfa_pkg::OP_ALLOC) begin
            w_scan_status = w_rpt_or.fail ? sfa_pkg::ST_NO_SPACE : sfa_pkg::ST_TABLE_FULL;
        end else begin
            w_scan_status = sfa_pkg::ST_NOT_FOUND;
        end
    end

    // Table update, issued for one cycle after a successful request.
    always_comb begin
        w_apply     = '0;
        w_apply.en  = (r_state == sfa_pkg::S_APPLY) && (r_res_status == sfa_pkg::ST_OK);
        w_apply.op  = r_ctl.op;
        w_apply.pos = r_res_slot;
        w_apply.at  = r_res_start;
        w_apply.len = r_ctl.len;
    end

    assign w_out_free = !r_o_valid || i_ready;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfa_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_imm ? sfa_pkg::S_APPLY : sfa_pkg::S_SCAN;
                end
            end
            sfa_pkg::S_SCAN: begin
                if (w_done) begin
                    n_state = sfa_pkg::S_APPLY;
                end
            end
            sfa_pkg::S_APPLY: begin
                n_state = w_out_free ? sfa_pkg::S_IDLE : sfa_pkg::S_DONE;
            end
            sfa_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = sfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sfa_pkg::S_IDLE;
            end
        endcase
    end

    // Request fields, scan position and pending result.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ctl.op     <= sfa_pkg::t_op'(i_op);
            r_ctl.desc   <= i_descriptor;
            r_ctl.len    <= i_total_length;
            r_ctl.need   <= sfa_pkg::units_of(i_total_length);
            r_ctl.vol    <= r_volume;
            r_k          <= '0;
            r_res_status <= r_read_only ? sfa_pkg::ST_NO_SPACE : sfa_pkg::ST_TABLE_FULL;
            r_res_slot   <= '0;
            r_res_start  <= '0;
        end else if (r_state == sfa_pkg::S_SCAN) begin
            r_k <= r_k + 6'd1;
            if (w_done) begin
                r_res_status <= w_scan_status;
                r_res_slot   <= w_scan_slot;
                r_res_start  <= w_scan_start;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == sfa_pkg::S_APPLY || r_state == sfa_pkg::S_DONE)
                     && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
        if ((r_state == sfa_pkg::S_APPLY || r_state == sfa_pkg::S_DONE) && w_out_free) begin
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
            r_o_start  <= r_res_start;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_slot       = r_o_slot;
    assign o_start_unit = r_o_start;

    // At most one cell stops the scan.
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit_vec))
        else $error("more than one cell reports a hit");

    // Used entries always form a prefix of the table.
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((w_vld >> 1) & ~w_vld) == '0))
        else $error("table has a gap between used entries");

    // The scan position never runs past the last cell.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfa_pkg::S_SCAN) |-> (32'(r_k) < MAX_ENTRIES))
        else $error("scan position out of range");

    // An update is never issued twice in a row.
    a_apply_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_apply.en |=> !w_apply.en)
        else $error("table update issued twice");

endmodule
